### src/normal_map_angular_error_core_macros.svh
// Assertion macros shared by the normal-map angular error core.
`ifndef NORMAL_MAP_ANGULAR_ERROR_CORE_MACROS_SVH
`define NORMAL_MAP_ANGULAR_ERROR_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define NMAE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define NMAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/nmae_pkg.sv
// Types, constants and the arctangent table of the normal-map angular error core.
`timescale 1ns / 1ps
`default_nettype none
package nmae_pkg;

	localparam int unsigned CORDIC_STEPS = 30;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [15:0] HEAT_SCALE  = 16'd45900;
	localparam logic [8:0]  CODE_OFFSET = 9'd127;
	localparam logic [7:0]  FS_RESET    = 8'd90;

	typedef struct packed {
		logic [7:0] gt_x;
		logic [7:0] gt_y;
		logic [7:0] gt_z;
		logic [7:0] est_x;
		logic [7:0] est_y;
		logic [7:0] est_z;
		logic       last_pixel;
	} in_item_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [15:0] angle_error;
		logic [7:0]  heat_value;
		logic        frame_done;
		logic [15:0] mean_error;
		logic [15:0] max_error;
		logic        error_flag;
	} out_item_t;

	// atan(2^-i) in Q30 radians
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### src/nmae_chan_if.sv
// Valid/ready channel carrying one payload of a chosen type.
`timescale 1ns / 1ps
`default_nettype none
interface nmae_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/nmae_sdiv.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nmae_sdiv #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 40,
	parameter int QUO_W = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [QUO_W-1:0] quot
);
	localparam int SH_W  = DEN_W + QUO_W - 1;
	localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
	localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

	logic [NUM_W-1:0] rem_q;
	logic [SH_W-1:0]  dsh_q;
	logic [QUO_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic             ge;

	// quotient assumed to fit QUO_W bits
	assign ge = CMP_W'(rem_q) >= CMP_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsh_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(QUO_W - 1));
			if (start) begin
				rem_q  <= num;
				dsh_q  <= SH_W'(den) << (QUO_W - 1);
				quot_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - NUM_W'(dsh_q);
				end
				quot_q <= {quot_q[QUO_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

### src/normal_map_angular_error_core.sv
// Top level of the normal-map angular error core.
// One transfer on pix_in carries an aligned pixel pair (ground truth and
// estimate, codes offset by 127); one transfer on res_out carries its result.
// A pixel counts when ground-truth channels 0 and 1 are nonzero and neither
// vector is zero-length. Its angle is found serially: the dot and cross
// products on one shared 18x18 multiplier, a two-bit-per-step square root
// of the cross magnitude, thirty CORDIC vectoring steps, then a restoring
// divider for the heat byte (sixteen quotient bits). A masked-out or
// zero-length pixel goes straight to its result; parallel vectors skip root
// and CORDIC. For the frame's last pixel the mean follows, reusing the
// divider unless no pixel of the frame was counted. A result held back
// by res_out stalls the block. One pixel is in work at a time; a finished
// result waits in the output register while the next pixel is taken.
// full_scale_deg (reset 90, 0 read as 1) is written through cfg; the user
// must do so only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none
`include "normal_map_angular_error_core_macros.svh"
module normal_map_angular_error_core #(
	parameter int MAX_FRAME_PIXELS = 1048576,
	parameter int ANGLE_FRAC_BITS  = 14
) (
	input wire logic   clk,
	input wire logic   arst_n,
	nmae_chan_if.sink   pix_in,
	nmae_chan_if.source res_out,
	nmae_chan_if.sink   cfg
);
	localparam int CNT_W   = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int SUM_W   = 16 + CNT_W;
	localparam int DIV_NW  = (SUM_W + 1 > 48) ? SUM_W + 1 : 48;
	localparam int DIV_DW  = (CNT_W > 40) ? CNT_W : 40;
	localparam int ANG_SH  = 30 - ANGLE_FRAC_BITS;
	localparam logic [32:0] ANG_RND = 33'd1 << (29 - ANGLE_FRAC_BITS);
	localparam logic [4:0]  LAST_STEP = 5'(nmae_pkg::CORDIC_STEPS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_SQRT, S_CORD, S_POST, S_HDIV, S_RES, S_MSTART, S_MDIV, S_FIN
	} state_t;

	state_t state_q;

	// captured pixel
	logic signed [8:0] gx_q, gy_q, gz_q, ex_q, ey_q, ez_q;
	logic last_q, pvalid_q, pflag_q, efrm_q;
	logic [4:0] step_q;

	// products
	logic signed [17:0] dot_q;
	logic signed [16:0] cx_q, cy_q, cz_q;
	logic [31:0] c2_q;

	// square root
	logic [59:0] rad_q;
	logic [31:0] rem_q;
	logic [29:0] root_q;

	// CORDIC
	logic signed [33:0] x_q, y_q, z_q;

	// per-pixel and frame results
	logic [15:0] angle_q, mean_q;
	logic [7:0]  heat_q, fs_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] largest_q;

	logic      out_valid_q;
	nmae_pkg::out_item_t out_q;

	// shared multiplier
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod;

	always_comb begin
		case (step_q)
			5'd0:    begin mul_a = 18'(gx_q); mul_b = 18'(ex_q); end
			5'd1:    begin mul_a = 18'(gy_q); mul_b = 18'(ey_q); end
			5'd2:    begin mul_a = 18'(gz_q); mul_b = 18'(ez_q); end
			5'd3:    begin mul_a = 18'(gy_q); mul_b = 18'(ez_q); end
			5'd4:    begin mul_a = 18'(gz_q); mul_b = 18'(ey_q); end
			5'd5:    begin mul_a = 18'(gz_q); mul_b = 18'(ex_q); end
			5'd6:    begin mul_a = 18'(gx_q); mul_b = 18'(ez_q); end
			5'd7:    begin mul_a = 18'(gx_q); mul_b = 18'(ey_q); end
			5'd8:    begin mul_a = 18'(gy_q); mul_b = 18'(ex_q); end
			5'd9:    begin mul_a = 18'(cx_q); mul_b = 18'(cx_q); end
			5'd10:   begin mul_a = 18'(cy_q); mul_b = 18'(cy_q); end
			5'd11:   begin mul_a = 18'(cz_q); mul_b = 18'(cz_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign prod = mul_a * mul_b;

	logic [31:0] c2_nx;
	assign c2_nx = c2_q + prod[31:0];

	// root step: two radicand bits in, one root bit out
	logic [33:0] trial_rem, trial;
	logic        sq_ge;
	logic [29:0] root_nx;
	assign trial_rem = {rem_q, rad_q[59:58]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign sq_ge     = trial_rem >= trial;
	assign root_nx   = {root_q[28:0], sq_ge};

	// CORDIC start vector; negative dot is rotated by -pi/2 first
	logic signed [33:0] x_init, y_init;
	assign x_init = {{2{dot_q[17]}}, dot_q, 14'd0};
	assign y_init = {4'd0, root_nx};

	logic signed [33:0] xs, ys, atan_ext;
	assign xs       = x_q >>> step_q;
	assign ys       = y_q >>> step_q;
	assign atan_ext = {2'b00, nmae_pkg::atan_q30(step_q)};

	// clamp to 0..pi, then round to the output format
	logic [31:0] zc;
	logic [32:0] qs;
	logic [15:0] qsat;
	assign zc = z_q[33] ? 32'd0 :
		(z_q > $signed({2'b00, nmae_pkg::PI_Q30})) ? nmae_pkg::PI_Q30 : z_q[31:0];
	assign qs   = ({1'b0, zc} + ANG_RND) >> ANG_SH;
	assign qsat = (|qs[32:16]) ? 16'hFFFF : qs[15:0];

	logic [7:0]  fs_eff;
	logic [47:0] heat_num;
	logic [39:0] heat_den;
	assign fs_eff   = (fs_q == 8'd0) ? 8'd1 : fs_q;
	assign heat_num = zc * nmae_pkg::HEAT_SCALE;
	assign heat_den = nmae_pkg::PI_Q30 * fs_eff;

	// divider shared by heat and mean
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [15:0]       div_quot;

	always_comb begin
		if (state_q == S_POST) begin
			div_num = DIV_NW'(heat_num);
			div_den = DIV_DW'(heat_den);
		end else begin
			div_num = DIV_NW'(sum_q) + DIV_NW'(cnt_q >> 1);
			div_den = DIV_DW'(cnt_q);
		end
	end
	assign div_start = (state_q == S_POST) || (state_q == S_MSTART && cnt_q != '0);

	nmae_sdiv #(.NUM_W(DIV_NW), .DEN_W(DIV_DW), .QUO_W(16)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	logic in_fire, out_free;
	nmae_pkg::in_item_t pin;
	assign pin      = pix_in.data;
	assign in_fire  = pix_in.valid && pix_in.ready;
	assign out_free = !out_valid_q || res_out.ready;

	// masked out, or a zero-length vector inside the mask
	logic pin_masked, pin_zero;
	assign pin_masked = (pin.gt_x == 8'd0) || (pin.gt_y == 8'd0);
	assign pin_zero   = (pin.gt_x == 8'd127 && pin.gt_y == 8'd127 && pin.gt_z == 8'd127) ||
		(pin.est_x == 8'd127 && pin.est_y == 8'd127 && pin.est_z == 8'd127);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gx_q <= '0; gy_q <= '0; gz_q <= '0;
			ex_q <= '0; ey_q <= '0; ez_q <= '0;
			last_q      <= 1'b0;
			pvalid_q    <= 1'b0;
			pflag_q     <= 1'b0;
			efrm_q      <= 1'b0;
			step_q      <= '0;
			dot_q       <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			c2_q        <= '0;
			rad_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			x_q <= '0; y_q <= '0; z_q <= '0;
			angle_q     <= '0;
			mean_q      <= '0;
			heat_q      <= '0;
			fs_q        <= nmae_pkg::FS_RESET;
			sum_q       <= '0;
			cnt_q       <= '0;
			largest_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg.valid) begin
				fs_q <= cfg.data;
			end
			// S_FIN reloads the output register itself
			if (out_valid_q && res_out.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						gx_q <= $signed({1'b0, pin.gt_x}  - nmae_pkg::CODE_OFFSET);
						gy_q <= $signed({1'b0, pin.gt_y}  - nmae_pkg::CODE_OFFSET);
						gz_q <= $signed({1'b0, pin.gt_z}  - nmae_pkg::CODE_OFFSET);
						ex_q <= $signed({1'b0, pin.est_x} - nmae_pkg::CODE_OFFSET);
						ey_q <= $signed({1'b0, pin.est_y} - nmae_pkg::CODE_OFFSET);
						ez_q <= $signed({1'b0, pin.est_z} - nmae_pkg::CODE_OFFSET);
						last_q   <= pin.last_pixel;
						pvalid_q <= 1'b0;
						pflag_q  <= !pin_masked && pin_zero;
						efrm_q   <= 1'b0;
						angle_q  <= '0;
						heat_q   <= '0;
						mean_q   <= '0;
						step_q   <= '0;
						if (pin_masked || pin_zero) begin
							state_q <= S_RES;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					step_q <= (step_q == 5'd11) ? '0 : step_q + 5'd1;
					case (step_q)
						5'd0:         dot_q <= prod[17:0];
						5'd1, 5'd2:   dot_q <= dot_q + prod[17:0];
						5'd3:         cx_q  <= prod[16:0];
						5'd4:         cx_q  <= cx_q - prod[16:0];
						5'd5:         cy_q  <= prod[16:0];
						5'd6:         cy_q  <= cy_q - prod[16:0];
						5'd7:         cz_q  <= prod[16:0];
						5'd8:         cz_q  <= cz_q - prod[16:0];
						5'd9:         c2_q  <= prod[31:0];
						default:      c2_q  <= c2_nx;
					endcase
					if (step_q == 5'd11) begin
						if (c2_nx == 32'd0) begin
							// parallel: same direction 0, opposite pi
							z_q <= (dot_q > 18'sd0) ? 34'sd0 :
								$signed({2'b00, nmae_pkg::PI_Q30});
							state_q <= S_POST;
						end else begin
							rad_q   <= {c2_nx, 28'd0};
							rem_q   <= '0;
							root_q  <= '0;
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					rem_q  <= sq_ge ? 32'(trial_rem - trial) : trial_rem[31:0];
					root_q <= root_nx;
					rad_q  <= rad_q << 2;
					step_q <= (step_q == LAST_STEP) ? '0 : step_q + 5'd1;
					if (step_q == LAST_STEP) begin
						if (dot_q < 18'sd0) begin
							x_q <= y_init;
							y_q <= -x_init;
							z_q <= $signed({2'b00, nmae_pkg::HALF_PI_Q30});
						end else begin
							x_q <= x_init;
							y_q <= y_init;
							z_q <= '0;
						end
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (y_q > 34'sd0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_ext;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_ext;
					end
					step_q <= (step_q == LAST_STEP) ? '0 : step_q + 5'd1;
					if (step_q == LAST_STEP) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					angle_q  <= qsat;
					pvalid_q <= 1'b1;
					state_q  <= S_HDIV;
				end
				S_HDIV: begin
					if (div_done) begin
						heat_q  <= (|div_quot[15:8]) ? 8'hFF : div_quot[7:0];
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (pvalid_q) begin
						if (cnt_q < CNT_W'(MAX_FRAME_PIXELS)) begin
							sum_q <= sum_q + SUM_W'(angle_q);
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (angle_q > largest_q) begin
							largest_q <= angle_q;
						end
					end
					state_q <= last_q ? S_MSTART : S_FIN;
				end
				S_MSTART: begin
					if (cnt_q == '0) begin
						efrm_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					if (div_done) begin
						mean_q  <= div_quot;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.pixel_valid <= pvalid_q;
						out_q.angle_error <= angle_q;
						out_q.heat_value  <= heat_q;
						out_q.frame_done  <= last_q;
						out_q.mean_error  <= mean_q;
						out_q.max_error   <= last_q ? largest_q : 16'd0;
						out_q.error_flag  <= pflag_q | efrm_q;
						if (last_q) begin
							sum_q     <= '0;
							cnt_q     <= '0;
							largest_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pix_in.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_q;

	`NMAE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_FRAME_PIXELS), "pixel count beyond frame limit")
	`NMAE_ASSERT_NEXT(a_accept_busy, in_fire, state_q != S_IDLE, "block idle after a transfer in")
	`NMAE_ASSERT_SAME(a_masked_zero, res_out.valid && !res_out.data.pixel_valid, res_out.data.heat_value == 8'd0 && res_out.data.angle_error == 16'd0, "uncounted pixel with nonzero angle or heat")
	`NMAE_ASSERT_SAME(a_flag_excl, res_out.valid && res_out.data.pixel_valid && !res_out.data.frame_done, !res_out.data.error_flag, "counted pixel flagged as error")
endmodule
`default_nettype wire
